// ----- rtl/core/swtn_pkg.sv -----
// ----------------------------------------------------------------------------
// swtn_pkg: shared types and constants of the skin weight normalizer
// Table geometry, cell operations, cell contents and fixed-point helpers.
// ----------------------------------------------------------------------------
package swtn_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEEP_MAX    = 4;
    localparam int SLOTS       = 4;
    localparam int BONE_W      = 8;
    localparam int WGT_W       = 16;
    localparam int SHARE_W     = 16;
    localparam int KEPT_W      = 3;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TOT_W       = WGT_W + 2;
    localparam int NUM_W       = 32;
    localparam int SLOT_W      = 2;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 104;

    typedef enum logic [5:0] {
        CELL_NOP   = 6'b000001,
        CELL_WRITE = 6'b000010,
        CELL_ADD   = 6'b000100,
        CELL_MARK  = 6'b001000,
        CELL_SHIFT = 6'b010000,
        CELL_KILL  = 6'b100000
    } cell_op_t;

    typedef struct packed {
        logic              dead;
        logic [BONE_W-1:0] bone;
        logic [WGT_W-1:0]  weight;
    } cell_data_t;

    // equal split when the surviving weights sum to zero
    function automatic logic [SHARE_W-1:0] even_share(input logic [KEPT_W-1:0] n);
        logic [SHARE_W-1:0] r;
        begin
            case (n)
                3'd1:    r = 16'd32768;
                3'd2:    r = 16'd16384;
                3'd3:    r = 16'd10922;
                3'd4:    r = 16'd8192;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/swtn_cell.sv -----
// ----------------------------------------------------------------------------
// swtn_cell: one influence table entry
// Holds bone id, weight and a drop mark; pulls from its right neighbor.
// ----------------------------------------------------------------------------
module swtn_cell (
    input  logic                         aclk,
    input  swtn_pkg::cell_op_t           op,
    input  logic [swtn_pkg::BONE_W-1:0]  add_bone,
    input  logic [swtn_pkg::WGT_W-1:0]   add_weight,
    input  logic [swtn_pkg::WGT_W-1:0]   threshold,
    input  swtn_pkg::cell_data_t         from_right,
    output swtn_pkg::cell_data_t         data,
    output logic                         hit
);

    swtn_pkg::cell_data_t data_reg, data_next;
    logic [swtn_pkg::WGT_W:0] sum;

    assign sum  = {1'b0, data_reg.weight} + {1'b0, add_weight};
    assign hit  = (data_reg.bone == add_bone);
    assign data = data_reg;

    always_comb begin
        data_next = data_reg;
        case (op)
            swtn_pkg::CELL_NOP: ;
            swtn_pkg::CELL_WRITE: begin
                data_next.bone   = add_bone;
                data_next.weight = add_weight;
                data_next.dead   = 1'b0;
            end
            swtn_pkg::CELL_ADD: begin
                data_next.weight = sum[swtn_pkg::WGT_W] ? '1 : sum[swtn_pkg::WGT_W-1:0];
            end
            swtn_pkg::CELL_MARK:  data_next.dead = (data_reg.weight < threshold);
            swtn_pkg::CELL_SHIFT: data_next = from_right;
            swtn_pkg::CELL_KILL:  data_next.dead = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

// ----- rtl/core/swtn_div.sv -----
// ----------------------------------------------------------------------------
// swtn_div: restoring divider, one quotient bit per cycle
// 32-bit dividend, 18-bit divisor, 16-bit quotient (quotient < 2^16).
// ----------------------------------------------------------------------------
module swtn_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [swtn_pkg::NUM_W-1:0]    num,
    input  logic [swtn_pkg::TOT_W-1:0]    den,
    output logic                          done,
    output logic [swtn_pkg::SHARE_W-1:0]  quo
);

    localparam int REM_W = swtn_pkg::TOT_W + 1;
    localparam int HALF  = swtn_pkg::NUM_W / 2;

    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [HALF-1:0]              lo_reg, lo_next;
    logic [swtn_pkg::SHARE_W-1:0] q_reg, q_next;
    logic [swtn_pkg::TOT_W-1:0]   den_reg, den_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [REM_W-1:0]             trial;

    assign trial = {rem_reg[REM_W-2:0], lo_reg[HALF-1]};
    assign done  = done_reg;
    assign quo   = q_reg;

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = REM_W'(num[swtn_pkg::NUM_W-1:HALF]);
            lo_next  = num[HALF-1:0];
            den_next = den;
            cnt_next = 5'(HALF);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[swtn_pkg::SHARE_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[swtn_pkg::SHARE_W-2:0], 1'b0};
            end
            lo_next  = {lo_reg[HALF-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ----- rtl/core/skin_weight_top4_normalizer.sv -----
// ----------------------------------------------------------------------------
// skin_weight_top4_normalizer: per-vertex bone influence collector
// Gathers influences in a row of table cells, prunes to four and normalizes.
// ----------------------------------------------------------------------------
// An add beat (tuser 0) has all cells compare the bone id at once and
// either accumulate or append, or flag an overflow when the table is full.
// A finalize beat (tuser 1) marks entries below the threshold, closes gaps
// by shifting cells left one place per cycle, evicts the smallest weights
// one at a time (a scan of the entries left plus a gap close each), then
// fills each of four slots, dividing a kept weight by the total with a one
// bit per cycle divider when the total is nonzero, else an even split. The
// result is held in an output register, and new beats are taken while it
// waits; a following finalize stalls until that result is taken.
// ----------------------------------------------------------------------------
module skin_weight_top4_normalizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [swtn_pkg::WGT_W-1:0]    cfg_wdata,   // weight_threshold
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [swtn_pkg::IN_W-1:0]     s_tdata,     // bone_id, add_weight
    input  logic                          s_tuser,     // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bone_a..bone_d, share_a..share_d, kept_count, table_overflowed
    output logic [swtn_pkg::OUT_W-1:0]    m_tdata
);

    localparam int D = swtn_pkg::TABLE_DEPTH;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_MARK    = 7'b0000010,
        ST_COMPACT = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_SUM     = 7'b0010000,
        ST_DIV     = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [swtn_pkg::WGT_W-1:0]     thr_reg;
    logic [swtn_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           ovf_reg, ovf_next;
    logic [swtn_pkg::CNT_W-1:0]     ptr_reg, ptr_next;
    logic [swtn_pkg::IDX_W-1:0]     minpos_reg, minpos_next;
    logic [swtn_pkg::WGT_W-1:0]     minw_reg, minw_next;
    logic [swtn_pkg::TOT_W-1:0]     total_reg, total_next;
    logic [swtn_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                           wait_reg, wait_next;
    logic [swtn_pkg::SHARE_W-1:0]   share_reg [swtn_pkg::SLOTS];
    logic                           m_valid_reg;
    logic [swtn_pkg::OUT_W-1:0]     m_data_reg;

    swtn_pkg::cell_op_t   op      [D];
    swtn_pkg::cell_data_t cdata   [D];
    swtn_pkg::cell_data_t right   [D];
    logic [D-1:0]         hit;
    logic [D-1:0]         hole;
    logic                 gap;
    logic [swtn_pkg::CNT_W-1:0] live_cnt;
    logic                 accept, any_hit;
    logic [swtn_pkg::BONE_W-1:0] in_bone;
    logic [swtn_pkg::WGT_W-1:0]  in_weight;
    logic [swtn_pkg::WGT_W-1:0]  scan_w;
    logic [swtn_pkg::TOT_W-1:0]  sum_all;
    logic                 div_start, div_done;
    logic [swtn_pkg::SHARE_W-1:0] div_q;
    logic [swtn_pkg::NUM_W-1:0]   div_num;
    logic [swtn_pkg::WGT_W-1:0]   slot_w;
    logic                 share_we;
    logic [swtn_pkg::SHARE_W-1:0] share_val;
    logic                 out_free;

    assign in_bone   = s_tdata[swtn_pkg::BONE_W-1:0];
    assign in_weight = s_tdata[swtn_pkg::BONE_W +: swtn_pkg::WGT_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    for (genvar k = 0; k < D; k++) begin : g_cell
        if (k == D - 1) begin : g_end
            assign right[k] = '{dead: 1'b1, bone: '0, weight: '0};
        end else begin : g_mid
            assign right[k] = cdata[k+1];
        end
        swtn_cell u_cell (
            .aclk       (aclk),
            .op         (op[k]),
            .add_bone   (in_bone),
            .add_weight (in_weight),
            .threshold  (thr_reg),
            .from_right (right[k]),
            .data       (cdata[k]),
            .hit        (hit[k])
        );
    end

    always_comb begin
        any_hit  = 1'b0;
        live_cnt = '0;
        gap      = 1'b0;
        for (int k = 0; k < D; k++) begin
            if (hit[k] && (swtn_pkg::CNT_W'(k) < count_reg)) any_hit = 1'b1;
            if (!cdata[k].dead) live_cnt = live_cnt + swtn_pkg::CNT_W'(1);
            hole[k] = (k == 0) ? cdata[k].dead : (hole[k-1] | cdata[k].dead);
            if (k > 0 && hole[k-1] && !cdata[k].dead) gap = 1'b1;
        end
    end

    assign scan_w = cdata[ptr_reg[swtn_pkg::IDX_W-1:0]].weight;

    always_comb begin
        sum_all = '0;
        for (int k = 0; k < swtn_pkg::KEEP_MAX; k++) begin
            if (swtn_pkg::CNT_W'(k) < count_reg)
                sum_all = sum_all + swtn_pkg::TOT_W'(cdata[k].weight);
        end
    end

    assign slot_w  = cdata[swtn_pkg::IDX_W'(slot_reg)].weight;
    assign div_num = {1'b0, slot_w, 15'd0} + swtn_pkg::NUM_W'(total_reg >> 1);

    swtn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (total_reg),
        .done    (div_done),
        .quo     (div_q)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        ptr_next    = ptr_reg;
        minpos_next = minpos_reg;
        minw_next   = minw_reg;
        total_next  = total_reg;
        slot_next   = slot_reg;
        wait_next   = wait_reg;
        div_start   = 1'b0;
        share_we    = 1'b0;
        share_val   = '0;
        for (int k = 0; k < D; k++) op[k] = swtn_pkg::CELL_NOP;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_tuser) begin
                    if (any_hit) begin
                        for (int k = 0; k < D; k++)
                            if (hit[k] && (swtn_pkg::CNT_W'(k) < count_reg))
                                op[k] = swtn_pkg::CELL_ADD;
                    end else if (count_reg < swtn_pkg::CNT_W'(D)) begin
                        op[count_reg[swtn_pkg::IDX_W-1:0]] = swtn_pkg::CELL_WRITE;
                        count_next = count_reg + swtn_pkg::CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end else if (accept) begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                for (int k = 0; k < D; k++)
                    op[k] = (swtn_pkg::CNT_W'(k) < count_reg) ? swtn_pkg::CELL_MARK
                                                              : swtn_pkg::CELL_KILL;
                state_next = ST_COMPACT;
            end
            ST_COMPACT: begin
                if (gap) begin
                    for (int k = 0; k < D; k++)
                        if (hole[k]) op[k] = swtn_pkg::CELL_SHIFT;
                end else begin
                    count_next = live_cnt;
                    if (live_cnt > swtn_pkg::CNT_W'(swtn_pkg::KEEP_MAX)) begin
                        ptr_next    = swtn_pkg::CNT_W'(1);
                        minpos_next = '0;
                        minw_next   = cdata[0].weight;
                        state_next  = ST_SCAN;
                    end else begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SCAN: begin
                if (ptr_reg < count_reg) begin
                    if (scan_w < minw_reg) begin
                        minw_next   = scan_w;
                        minpos_next = ptr_reg[swtn_pkg::IDX_W-1:0];
                    end
                    ptr_next = ptr_reg + swtn_pkg::CNT_W'(1);
                end else begin
                    op[minpos_reg] = swtn_pkg::CELL_KILL;
                    state_next     = ST_COMPACT;
                end
            end
            ST_SUM: begin
                total_next = sum_all;
                slot_next  = '0;
                wait_next  = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (wait_reg) begin
                    if (div_done) begin
                        share_we  = 1'b1;
                        share_val = div_q;
                        wait_next = 1'b0;
                    end
                end else if ({1'b0, slot_reg} < count_reg[swtn_pkg::SLOT_W:0] &&
                             count_reg[swtn_pkg::CNT_W-1:swtn_pkg::SLOT_W+1] == '0 &&
                             total_reg != '0) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else begin
                    share_we  = 1'b1;
                    share_val = (swtn_pkg::CNT_W'(slot_reg) < count_reg)
                              ? swtn_pkg::even_share(count_reg[swtn_pkg::KEPT_W-1:0]) : '0;
                end
                if (share_we) begin
                    slot_next = slot_reg + swtn_pkg::SLOT_W'(1);
                    if (slot_reg == swtn_pkg::SLOT_W'(swtn_pkg::SLOTS - 1))
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            wait_reg  <= wait_next;
            if (cfg_we) thr_reg <= cfg_wdata;
            if (state_reg == ST_EMIT && out_free) m_valid_reg <= 1'b1;
            else if (m_tready)                    m_valid_reg <= 1'b0;
        end
        ptr_reg    <= ptr_next;
        minpos_reg <= minpos_next;
        minw_reg   <= minw_next;
        total_reg  <= total_next;
        slot_reg   <= slot_next;
        if (share_we) share_reg[slot_reg] <= share_val;
        if (state_reg == ST_EMIT && out_free) begin
            for (int k = 0; k < swtn_pkg::SLOTS; k++) begin
                m_data_reg[k*swtn_pkg::BONE_W +: swtn_pkg::BONE_W] <=
                    (swtn_pkg::CNT_W'(k) < count_reg) ? cdata[k].bone : '0;
                m_data_reg[32 + k*swtn_pkg::SHARE_W +: swtn_pkg::SHARE_W] <= share_reg[k];
            end
            m_data_reg[96 +: swtn_pkg::KEPT_W] <= count_reg[swtn_pkg::KEPT_W-1:0];
            m_data_reg[99]      <= ovf_reg;
            m_data_reg[103:100] <= '0;
        end
    end

endmodule

// ----- rtl/core/swtn_checker.sv -----
// ----------------------------------------------------------------------------
// swtn_checker: port-level checks of the skin weight normalizer
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module swtn_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [swtn_pkg::OUT_W-1:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[98:96] <= 3'd4)
        else $error("kept count above four");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[98:96] == 3'd0 |-> m_tdata[95:0] == '0)
        else $error("empty vertex with nonzero slots");

endmodule

bind skin_weight_top4_normalizer swtn_checker u_swtn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
